FILE: design/rgbwenc_pkg.sv
// ----------------------------------------------------------------------------
// RGBW encoder package
// Shared word types, register indexes, reset values and phase codes.
// ----------------------------------------------------------------------------
package rgbwenc_pkg;

    localparam int PERIOD_W = 10;
    localparam int GAP_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PIXEL_BITS = 32;
    localparam int BITS_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_GAP  = 2'd3;

    localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD = 10'd80;
    localparam logic [PERIOD_W-1:0] RST_ZERO_HIGH  = 10'd19;
    localparam logic [PERIOD_W-1:0] RST_ONE_HIGH   = 10'd39;
    localparam logic [GAP_W-1:0]    RST_LATCH_GAP  = 16'd6400;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BITS  = 2'd1;
    localparam logic [1:0] PH_LATCH = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
        logic       end_of_frame;
    } in_word_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic pixel_dropped;
    } out_word_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period_cycles;
        logic [PERIOD_W-1:0] zero_high_cycles;
        logic [PERIOD_W-1:0] one_high_cycles;
        logic [GAP_W-1:0]    latch_gap_cycles;
    } cfg_t;

endpackage

FILE: design/rgbw_led_serial_encoder.sv
// A word accepted on s_ is registered in the result buffer before it is offered on m_.
// Throughput: one word per cycle while m_ready stays high; a two-entry
// result buffer (output register plus skid) keeps s_ready off the m_ready
// path, and s_ready drops only while both entries are full.
// Reset: aresetn low clears line state to idle, config to its defaults
// and empties the result buffer.
// ----------------------------------------------------------------------------
// RGBW single-wire LED encoder
// Turns pixel and tick words into line levels for a one-wire RGBW chain.
// ----------------------------------------------------------------------------
module rgbw_led_serial_encoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rgbwenc_pkg::in_word_t               s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rgbwenc_pkg::out_word_t              m_data,
    input  logic                                cfg_we,
    input  logic [rgbwenc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbwenc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rgbwenc_pkg::*;

    cfg_t      cfg;
    out_word_t res;
    logic      accept;

    assign accept = s_valid && s_ready;

    rgbwenc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rgbwenc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (accept),
        .in_word (s_data),
        .res     (res)
    );

    rgbwenc_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_word  (res),
        .push_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: design/rgbwenc_cfg.sv
// ----------------------------------------------------------------------------
// RGBW encoder configuration registers
// Holds bit timing and latch gap, written through a plain write port.
// ----------------------------------------------------------------------------
module rgbwenc_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [rgbwenc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbwenc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output rgbwenc_pkg::cfg_t                    cfg
);
    import rgbwenc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_period_cycles <= RST_BIT_PERIOD;
            cfg_reg.zero_high_cycles  <= RST_ZERO_HIGH;
            cfg_reg.one_high_cycles   <= RST_ONE_HIGH;
            cfg_reg.latch_gap_cycles  <= RST_LATCH_GAP;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BIT_PERIOD: cfg_reg.bit_period_cycles <= cfg_wdata[PERIOD_W-1:0];
                CFG_ZERO_HIGH:  cfg_reg.zero_high_cycles  <= cfg_wdata[PERIOD_W-1:0];
                CFG_ONE_HIGH:   cfg_reg.one_high_cycles   <= cfg_wdata[PERIOD_W-1:0];
                CFG_LATCH_GAP:  cfg_reg.latch_gap_cycles  <= cfg_wdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/rgbwenc_core.sv
// ----------------------------------------------------------------------------
// RGBW encoder core
// Line state registers and the single-pass step for one accepted word.
// ----------------------------------------------------------------------------
module rgbwenc_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rgbwenc_pkg::cfg_t       cfg,
    input  logic                    step,
    input  rgbwenc_pkg::in_word_t   in_word,
    output rgbwenc_pkg::out_word_t  res
);
    import rgbwenc_pkg::*;

    logic [PIXEL_BITS-1:0] bit_shift_reg,     bit_shift_next;
    logic [BITS_W-1:0]     bits_left_reg,     bits_left_next;
    logic [PERIOD_W-1:0]   tick_in_bit_reg,   tick_in_bit_next;
    logic [GAP_W-1:0]      latch_left_reg,    latch_left_next;
    logic                  latch_pending_reg, latch_pending_next;
    logic [1:0]            phase_reg,         phase_next;

    logic                  busy_now;
    logic [PERIOD_W-1:0]   tick_inc;
    logic [BITS_W-1:0]     bits_dec;
    logic [GAP_W-1:0]      latch_dec;

    function automatic logic level_of(input logic [1:0] ph, input logic msb,
                                      input logic [PERIOD_W-1:0] tick,
                                      input cfg_t c);
        logic [PERIOD_W-1:0] high;
        high = msb ? c.one_high_cycles : c.zero_high_cycles;
        return (ph == PH_BITS) && (tick < high);
    endfunction

    assign busy_now  = (phase_reg == PH_BITS) || (phase_reg == PH_LATCH);
    assign tick_inc  = tick_in_bit_reg + 1'b1;
    assign bits_dec  = bits_left_reg - 1'b1;
    assign latch_dec = latch_left_reg - 1'b1;

    always_comb begin
        bit_shift_next     = bit_shift_reg;
        bits_left_next     = bits_left_reg;
        tick_in_bit_next   = tick_in_bit_reg;
        latch_left_next    = latch_left_reg;
        latch_pending_next = latch_pending_reg;
        phase_next         = phase_reg;
        res                = '0;

        if (in_word.req_type == REQ_PIXEL) begin
            if (busy_now) begin
                res.pixel_dropped = 1'b1;
            end else begin
                bit_shift_next     = {in_word.green, in_word.red, in_word.blue, in_word.white};
                bits_left_next     = BITS_W'(PIXEL_BITS);
                tick_in_bit_next   = '0;
                latch_pending_next = in_word.end_of_frame;
                phase_next         = PH_BITS;
            end
            res.line_level = level_of(phase_next, bit_shift_next[PIXEL_BITS-1],
                                      tick_in_bit_next, cfg);
            res.busy_res   = (phase_next == PH_BITS) || (phase_next == PH_LATCH);
        end else begin
            case (phase_reg)
                PH_BITS: begin
                    res.line_level   = level_of(phase_reg, bit_shift_reg[PIXEL_BITS-1],
                                                tick_in_bit_reg, cfg);
                    res.busy_res     = 1'b1;
                    tick_in_bit_next = tick_inc;
                    if (tick_inc == '0 || tick_inc >= cfg.bit_period_cycles) begin
                        tick_in_bit_next = '0;
                        bit_shift_next   = {bit_shift_reg[PIXEL_BITS-2:0], 1'b0};
                        bits_left_next   = bits_dec;
                        if (bits_dec == '0) begin
                            if (latch_pending_reg && cfg.latch_gap_cycles != '0) begin
                                latch_left_next = cfg.latch_gap_cycles;
                                phase_next      = PH_LATCH;
                            end else begin
                                phase_next = PH_IDLE;
                            end
                            latch_pending_next = 1'b0;
                        end
                    end
                end
                PH_LATCH: begin
                    res.busy_res    = 1'b1;
                    latch_left_next = latch_dec;
                    if (latch_dec == '0) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_shift_reg     <= '0;
            bits_left_reg     <= '0;
            tick_in_bit_reg   <= '0;
            latch_left_reg    <= '0;
            latch_pending_reg <= 1'b0;
            phase_reg         <= PH_IDLE;
        end else if (step) begin
            bit_shift_reg     <= bit_shift_next;
            bits_left_reg     <= bits_left_next;
            tick_in_bit_reg   <= tick_in_bit_next;
            latch_left_reg    <= latch_left_next;
            latch_pending_reg <= latch_pending_next;
            phase_reg         <= phase_next;
        end
    end

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3) else $error("unused phase code entered");

    a_bits_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BITS |-> bits_left_reg != '0 && bits_left_reg <= BITS_W'(PIXEL_BITS))
        else $error("bit count out of range while sending");

    a_latch_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LATCH |-> latch_left_reg != '0 && !latch_pending_reg)
        else $error("latch gap state inconsistent");

    a_idle_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_word.req_type == REQ_TICK && phase_reg == PH_LATCH &&
        latch_left_reg == GAP_W'(1) |=> phase_reg == PH_IDLE)
        else $error("latch gap did not end");

endmodule

FILE: design/rgbwenc_obuf.sv
// ----------------------------------------------------------------------------
// RGBW encoder result buffer
// Output register with a skid stage so s_ready is registered, off the m_ready path.
// ----------------------------------------------------------------------------
module rgbwenc_obuf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  rgbwenc_pkg::out_word_t  push_word,
    output logic                    push_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rgbwenc_pkg::out_word_t  m_data
);
    import rgbwenc_pkg::*;

    out_word_t main_reg;
    out_word_t skid_reg;
    logic      main_valid_reg;
    logic      skid_valid_reg;
    logic      pop;

    assign pop        = main_valid_reg && m_ready;
    assign push_ready = !skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_data     = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg       <= push_word;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= push_word;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg) else $error("skid word without main word");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push) else $error("word pushed into full buffer");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && pop |=> !skid_valid_reg && main_valid_reg)
        else $error("skid word lost on drain");

endmodule
